// ===== hdl/assert_macros.svh =====
// assertion helpers, sampled on clk; HTE_ASSERT is held off while rst_n is low, HTE_ASSERT_ALWAYS is not
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define HTE_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hte assertion failed");
`define HTE_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("hte assertion failed during or after reset");
`else
`define HTE_ASSERT(label, prop)
`define HTE_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ===== hdl/hte_pkg.sv =====
`timescale 1ns / 1ps

package hte_pkg;

  localparam int PAYLOAD_BYTES = 60;
  localparam int PKT_BYTES     = PAYLOAD_BYTES + 4;
  localparam int WIN_DEPTH     = 64;
  localparam int AW            = $clog2(WIN_DEPTH);
  localparam int LEN_W         = $clog2(WIN_DEPTH + 1);
  localparam int CNT_W         = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

  localparam logic [7:0] HDR_A = 8'hFF;
  localparam logic [7:0] HDR_B = 8'hFE;
  localparam logic [7:0] TRL_A = 8'h00;
  localparam logic [7:0] TRL_B = 8'h01;

  typedef struct packed {
    logic          en;
    logic [AW-1:0] addr;
    logic [7:0]    data;
  } ram_wr_t;

  typedef struct packed {
    logic       load;
    logic [7:0] data;
    logic       last;
  } emit_t;

  typedef struct packed {
    logic valid;
    logic taken;
  } out_stat_t;

endpackage

// ===== hdl/header_tail_frame_extractor.sv =====
// frame extractor: hunts header ff fe, checks trailer 00 01, emits the payload
// readout: a byte that completes a good frame starts a ram read in S_RD; each payload byte
//   is loaded in S_CAP and held in S_OUT until taken; input is held until the last one
// throughput: one rx byte per cycle while hunting or filling in S_IDLE; a bad trailer
//   stalls the input for a rescan through the single window ram read port
// reset: synchronous active-low rst_n empties the window and drops any pending output
`timescale 1ns / 1ps

module header_tail_frame_extractor
  import hte_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_payload_byte,
  output logic       out_is_last
);

  // window ram ports
  ram_wr_t       ram_wr;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  // control to output stage and back
  emit_t         emit;
  out_stat_t     ostat;

  // output transaction register
  logic          out_valid_r;
  logic [7:0]    out_byte_r;
  logic          out_last_r;

  hte_window_ram u_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  hte_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_rx_byte),
    .ram_wr   (ram_wr),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .emit     (emit),
    .ostat    (ostat)
  );

  // a transaction leaves when valid and not stalled
  assign ostat.valid = out_valid_r;
  assign ostat.taken = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.load) begin
      out_valid_r <= 1'b1;
    end else if (ostat.taken) begin
      out_valid_r <= 1'b0;
    end
    // payload holds while stalled since the controller loads only when empty
    if (emit.load) begin
      out_byte_r <= emit.data;
      out_last_r <= emit.last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_payload_byte = out_byte_r;
  assign out_is_last      = out_last_r;

endmodule

// ===== hdl/hte_window_ram.sv =====
`timescale 1ns / 1ps

module hte_window_ram
  import hte_pkg::*;
(
  input  logic          clk,
  input  ram_wr_t       wr,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [WIN_DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/hte_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hte_ctrl
  import hte_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_byte,
  output ram_wr_t       ram_wr,
  output logic [AW-1:0] rd_addr,
  input  logic [7:0]    rd_data,
  output emit_t         emit,
  input  out_stat_t     ostat
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CAP,
    S_OUT,
    S_SCAN0,
    S_SCAN
  } state_t;

  localparam logic [LEN_W-1:0] LEN_LAST  = LEN_W'(PKT_BYTES - 1);
  localparam logic [LEN_W-1:0] LEN_END   = LEN_W'(PKT_BYTES + 1);
  localparam logic [AW-1:0]    POS_LAST  = AW'(PKT_BYTES - 1);
  localparam logic [AW-1:0]    OFS_PAY   = AW'(2);
  localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(PAYLOAD_BYTES - 1);

  state_t           state_r, state_nxt;
  logic [AW-1:0]    head_r, head_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [7:0]       prev_r, prev_nxt;
  logic [AW-1:0]    ptr_r, ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0]    pos_r, pos_nxt;
  logic             prev_ff_r, prev_ff_nxt;
  logic             accept;
  logic [AW-1:0]    tail_addr;
  logic             frame_done;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && (state_r == S_IDLE);
  assign tail_addr = head_r + len_r[AW-1:0];
  assign rd_addr   = ptr_r;

  assign emit.load = (state_r == S_CAP);
  assign emit.data = rd_data;
  assign emit.last = (cnt_r == CNT_LAST);

  // final payload byte of a frame leaves this cycle
  assign frame_done = (state_r == S_OUT) && ostat.taken && emit.last;

  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    len_nxt     = len_r;
    prev_nxt    = prev_r;
    ptr_nxt     = ptr_r;
    cnt_nxt     = cnt_r;
    pos_nxt     = pos_r;
    prev_ff_nxt = prev_ff_r;
    ram_wr.en   = 1'b0;
    ram_wr.addr = tail_addr;
    ram_wr.data = in_byte;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          priority if (len_r == '0) begin
            if (in_byte == HDR_A) begin
              ram_wr.en = 1'b1;
              len_nxt   = LEN_W'(1);
              prev_nxt  = in_byte;
            end
          end else if (len_r == LEN_W'(1)) begin
            // window holds a lone ff
            if (in_byte == HDR_B) begin
              ram_wr.en = 1'b1;
              len_nxt   = LEN_W'(2);
              prev_nxt  = in_byte;
            end else if (in_byte != HDR_A) begin
              len_nxt = '0;
            end
          end else if (len_r != LEN_LAST) begin
            ram_wr.en = 1'b1;
            len_nxt   = len_r + LEN_W'(1);
            prev_nxt  = in_byte;
          end else begin
            // packet complete: check trailer
            ram_wr.en = 1'b1;
            prev_nxt  = in_byte;
            ptr_nxt   = head_r + OFS_PAY;
            cnt_nxt   = '0;
            if (prev_r == TRL_A && in_byte == TRL_B) begin
              state_nxt = S_RD;
            end else begin
              state_nxt = S_SCAN0;
            end
          end
        end
      end
      S_RD: begin
        ptr_nxt   = ptr_r + AW'(1);
        state_nxt = S_CAP;
      end
      S_CAP: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (ostat.taken) begin
          if (emit.last) begin
            len_nxt   = '0;
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt   = cnt_r + CNT_W'(1);
            ptr_nxt   = ptr_r + AW'(1);
            state_nxt = S_CAP;
          end
        end
      end
      S_SCAN0: begin
        ptr_nxt     = ptr_r + AW'(1);
        pos_nxt     = OFS_PAY;
        prev_ff_nxt = 1'b0;
        state_nxt   = S_SCAN;
      end
      S_SCAN: begin
        priority if (prev_ff_r && rd_data == HDR_B) begin
          // header starts one position back
          head_nxt  = head_r + pos_r - AW'(1);
          len_nxt   = LEN_END - LEN_W'(pos_r);
          state_nxt = S_IDLE;
        end else if (pos_r == POS_LAST) begin
          if (rd_data == HDR_A) begin
            head_nxt = head_r + POS_LAST;
            len_nxt  = LEN_W'(1);
          end else begin
            len_nxt = '0;
          end
          state_nxt = S_IDLE;
        end else begin
          prev_ff_nxt = (rd_data == HDR_A);
          pos_nxt     = pos_r + AW'(1);
          ptr_nxt     = ptr_r + AW'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      len_r   <= '0;
      head_r  <= '0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      head_r  <= head_nxt;
    end
    prev_r    <= prev_nxt;
    ptr_r     <= ptr_nxt;
    cnt_r     <= cnt_nxt;
    pos_r     <= pos_nxt;
    prev_ff_r <= prev_ff_nxt;
  end

  `HTE_ASSERT(a_len_bound, (state_r == S_IDLE) |-> (len_r < LEN_W'(PKT_BYTES)))
  `HTE_ASSERT(a_frame_clears, frame_done |=> (state_r == S_IDLE && len_r == '0))
  `HTE_ASSERT(a_out_held, (state_r == S_OUT) |-> ostat.valid)
  `HTE_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == S_IDLE && len_r == '0))

endmodule
